// ===== src/cbct_pkg.sv =====
package cbct_pkg;

    localparam int BOX_W   = 48;
    localparam int CHAN_W  = 8;
    localparam int HITS_W  = 23;
    localparam int SUM_W   = 34;
    localparam int COORD_W = 11;
    localparam int CFG_IDX_W = 2;

    // frame summaries waiting for the divider
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // divider step counter
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [CFG_IDX_W-1:0] REG_RED_BOX   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_BOX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_BOX = 2'd2;

    // byte layout: low b,g,r in bytes 0-2, high b,g,r in bytes 3-5
    localparam logic [BOX_W-1:0] RED_BOX_RESET   = 48'hFF6464_960000;
    localparam logic [BOX_W-1:0] BLUE_BOX_RESET  = 48'h6464FF_000096;
    localparam logic [BOX_W-1:0] GREEN_BOX_RESET = 48'h64FF64_009600;

    typedef struct packed {
        logic [HITS_W-1:0] hits;
        logic [SUM_W-1:0]  col_sum;
        logic [SUM_W-1:0]  row_sum;
        logic              blue_seen;
        logic              green_seen;
    } frame_sum_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== src/cbct_front.sv =====
module cbct_front
    import cbct_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BOX_W-1:0]     cfg_data,
    input  logic                 accept,
    input  logic [CHAN_W-1:0]    blue_value,
    input  logic [CHAN_W-1:0]    green_value,
    input  logic [CHAN_W-1:0]    red_value,
    input  logic                 start_of_frame,
    input  logic                 end_of_line,
    input  logic                 end_of_frame,
    output logic                 sum_push,
    output frame_sum_t           sum_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [CW-1:0]     COL_LAST = CW'(MAX_WIDTH - 1);
    localparam logic [RW-1:0]     ROW_LAST = RW'(MAX_HEIGHT - 1);
    localparam logic [HITS_W-1:0] HITS_MAX = '1;

    function automatic logic chan_in(input logic [BOX_W-1:0] box, input int lane,
                                     input logic [CHAN_W-1:0] v);
        logic [CHAN_W-1:0] lo;
        logic [CHAN_W-1:0] hi;
        lo = box[lane*CHAN_W +: CHAN_W];
        hi = box[(lane+3)*CHAN_W +: CHAN_W];
        return (lo <= v) && (v <= hi);
    endfunction

    function automatic logic box_hit(input logic [BOX_W-1:0] box,
                                     input logic [CHAN_W-1:0] b,
                                     input logic [CHAN_W-1:0] g,
                                     input logic [CHAN_W-1:0] r);
        return chan_in(box, 0, b) && chan_in(box, 1, g) && chan_in(box, 2, r);
    endfunction

    logic [BOX_W-1:0]  red_box_reg, blue_box_reg, green_box_reg;
    logic [CW-1:0]     col_reg, col_next, col_e;
    logic [RW-1:0]     row_reg, row_next, row_e;
    logic [HITS_W-1:0] hits_reg, hits_next, hits_e;
    logic [SUM_W-1:0]  csum_reg, csum_next, csum_e;
    logic [SUM_W-1:0]  rsum_reg, rsum_next, rsum_e;
    logic              blue_reg, blue_next, blue_e;
    logic              green_reg, green_next, green_e;
    logic [SUM_W:0]    col_add, row_add;
    logic              red_take;

    always_comb begin
        // start marker clears before the pixel counts
        col_e   = start_of_frame ? '0 : col_reg;
        row_e   = start_of_frame ? '0 : row_reg;
        hits_e  = start_of_frame ? '0 : hits_reg;
        csum_e  = start_of_frame ? '0 : csum_reg;
        rsum_e  = start_of_frame ? '0 : rsum_reg;
        blue_e  = start_of_frame ? 1'b0 : blue_reg;
        green_e = start_of_frame ? 1'b0 : green_reg;

        col_add = {1'b0, csum_e} + (SUM_W+1)'(col_e);
        row_add = {1'b0, rsum_e} + (SUM_W+1)'(row_e);
        // hit dropped when any accumulator would overflow
        red_take = box_hit(red_box_reg, blue_value, green_value, red_value) &&
                   (hits_e != HITS_MAX) && !col_add[SUM_W] && !row_add[SUM_W];

        sum_data.hits       = red_take ? hits_e + 1'b1 : hits_e;
        sum_data.col_sum    = red_take ? col_add[SUM_W-1:0] : csum_e;
        sum_data.row_sum    = red_take ? row_add[SUM_W-1:0] : rsum_e;
        sum_data.blue_seen  = blue_e |
                              box_hit(blue_box_reg, blue_value, green_value, red_value);
        sum_data.green_seen = green_e |
                              box_hit(green_box_reg, blue_value, green_value, red_value);

        hits_next  = sum_data.hits;
        csum_next  = sum_data.col_sum;
        rsum_next  = sum_data.row_sum;
        blue_next  = sum_data.blue_seen;
        green_next = sum_data.green_seen;
        col_next   = col_e;
        row_next   = row_e;

        if (end_of_frame) begin
            hits_next  = '0;
            csum_next  = '0;
            rsum_next  = '0;
            blue_next  = 1'b0;
            green_next = 1'b0;
            col_next   = '0;
            row_next   = '0;
        end else if (end_of_line) begin
            col_next = '0;
            if (row_e < ROW_LAST) row_next = row_e + 1'b1;
        end else begin
            if (col_e < COL_LAST) col_next = col_e + 1'b1;
        end
    end

    assign sum_push = accept && end_of_frame;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_box_reg   <= RED_BOX_RESET;
            blue_box_reg  <= BLUE_BOX_RESET;
            green_box_reg <= GREEN_BOX_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            hits_reg      <= '0;
            csum_reg      <= '0;
            rsum_reg      <= '0;
            blue_reg      <= 1'b0;
            green_reg     <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_RED_BOX:   red_box_reg   <= cfg_data;
                    REG_BLUE_BOX:  blue_box_reg  <= cfg_data;
                    REG_GREEN_BOX: green_box_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                hits_reg  <= hits_next;
                csum_reg  <= csum_next;
                rsum_reg  <= rsum_next;
                blue_reg  <= blue_next;
                green_reg <= green_next;
            end
        end
    end

endmodule

// ===== src/cbct_queue.sv =====
module cbct_queue
    import cbct_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  frame_sum_t    push_data,
    input  logic          pop,
    output frame_sum_t    pop_data,
    output queue_status_t status
);

    frame_sum_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push, do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push  = push && !status.full;
    assign do_pop   = pop && !status.empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)      count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== src/cbct_back.sv =====
module cbct_back
    import cbct_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  queue_status_t      q_status,
    input  frame_sum_t         q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               red_found,
    output logic [COORD_W-1:0] cursor_x,
    output logic [COORD_W-1:0] cursor_y,
    output logic               right_click,
    output logic               left_click
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic [HITS_W-1:0] div_reg;
    logic [HITS_W-1:0] rem_x_reg, rem_y_reg, rem_x_next, rem_y_next;
    logic [SUM_W-1:0]  quo_x_reg, quo_y_reg, quo_x_next, quo_y_next;
    logic              found_reg, blue_reg, green_reg;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [HITS_W+SUM_W-1:0] div_step(input logic [HITS_W-1:0] rem,
                                                         input logic [SUM_W-1:0] quo,
                                                         input logic [HITS_W-1:0] d);
        logic [HITS_W:0] trial;
        logic [HITS_W:0] diff;
        logic            ge;
        trial = {rem, quo[SUM_W-1]};
        diff  = trial - {1'b0, d};
        ge    = (trial >= {1'b0, d});
        return {ge ? diff[HITS_W-1:0] : trial[HITS_W-1:0], quo[SUM_W-2:0], ge};
    endfunction

    always_comb begin
        {rem_x_next, quo_x_next} = div_step(rem_x_reg, quo_x_reg, div_reg);
        {rem_y_next, quo_y_next} = div_step(rem_y_reg, quo_y_reg, div_reg);
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    q_pop      = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (step_reg == '0) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            div_reg   <= q_data.hits;
            rem_x_reg <= '0;
            rem_y_reg <= '0;
            quo_x_reg <= q_data.col_sum;
            quo_y_reg <= q_data.row_sum;
            found_reg <= (q_data.hits != '0);
            blue_reg  <= q_data.blue_seen;
            green_reg <= q_data.green_seen;
            step_reg  <= STEP_W'(SUM_W - 1);
        end else if (state_reg == ST_DIV) begin
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            quo_x_reg <= quo_x_next;
            quo_y_reg <= quo_y_next;
            step_reg  <= step_reg - 1'b1;
        end
    end

    assign m_valid     = (state_reg == ST_DONE);
    assign red_found   = found_reg;
    // no red hits: the quotient is meaningless, report zero
    assign cursor_x    = found_reg ? quo_x_reg[COORD_W-1:0] : '0;
    assign cursor_y    = found_reg ? quo_y_reg[COORD_W-1:0] : '0;
    assign right_click = blue_reg;
    assign left_click  = green_reg;

endmodule

// ===== src/color_box_centroid_tracker_top.sv =====
// color box centroid tracker
// input channel (s_*): one BGR pixel per transaction with start_of_frame,
//   end_of_line and end_of_frame markers; s_ready is high while the frame
//   summary queue has room, so pixels normally stream at one per cycle
// result channel (m_*): one transaction per frame, issued after the
//   end_of_frame pixel: red presence, truncated red centroid, blue presence
//   as right_click and green presence as left_click
// config port: cfg_write with cfg_index 0 red, 1 blue, 2 green box;
//   cfg_data is the packed low/high byte bounds; other indexes are ignored
// result path: with the back end idle, the summary is popped after the end_of_frame
//   pixel, then the bit-serial divider works through the 34-bit sums one bit at a
//   time before m_valid rises
// throughput: one pixel per cycle; the divider takes the next frame summary only
//   after the wait on m_ready, and a two-entry summary queue lets the next
//   frames accumulate meanwhile; with the queue full, s_ready drops
// reset: synchronous active-low aresetn restores the default color boxes,
//   clears counters, accumulators and the queue, and drops m_valid
// receiver stall: the result holds on m_* until m_ready; pixels keep
//   flowing until the queue fills
module color_box_centroid_tracker_top
    import cbct_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BOX_W-1:0]     cfg_data,
    // pixel stream
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CHAN_W-1:0]    s_blue_value,
    input  logic [CHAN_W-1:0]    s_green_value,
    input  logic [CHAN_W-1:0]    s_red_value,
    input  logic                 s_start_of_frame,
    input  logic                 s_end_of_line,
    input  logic                 s_end_of_frame,
    // per-frame result
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_red_found,
    output logic [COORD_W-1:0]   m_cursor_x,
    output logic [COORD_W-1:0]   m_cursor_y,
    output logic                 m_right_click,
    output logic                 m_left_click
);

    logic          s_accept;
    logic          sum_push;
    frame_sum_t    sum_data;
    frame_sum_t    q_data;
    logic          q_pop;
    queue_status_t q_status;

    // the queue must take the summary of any pixel we accept
    assign s_ready  = !q_status.full;
    assign s_accept = s_valid && s_ready;

    // front: color box tests and per-frame accumulation
    cbct_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .accept         (s_accept),
        .blue_value     (s_blue_value),
        .green_value    (s_green_value),
        .red_value      (s_red_value),
        .start_of_frame (s_start_of_frame),
        .end_of_line    (s_end_of_line),
        .end_of_frame   (s_end_of_frame),
        .sum_push       (sum_push),
        .sum_data       (sum_data)
    );

    // frame summaries between accumulation and division
    cbct_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (sum_push),
        .push_data (sum_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .status    (q_status)
    );

    // back: serial centroid division and result register
    cbct_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_status    (q_status),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .red_found   (m_red_found),
        .cursor_x    (m_cursor_x),
        .cursor_y    (m_cursor_y),
        .right_click (m_right_click),
        .left_click  (m_left_click)
    );

endmodule
